// File: hdl/ilir_pkg.sv
// ilir_pkg: shared types, sizes and codes of the indexed list block
// used by ilir_front, ilir_back and indexed_list_insert_remove; no dependencies
package ilir_pkg;

   localparam int CAPACITY   = 1024;
   localparam int ELEM_BITS  = 8;
   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);

   // port field widths are fixed by the interface
   localparam int TYPE_W     = 3;
   localparam int INDEX_W    = 10;
   localparam int DATA_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 11;

   // compare width: holds the count and index plus two
   localparam int CMP_BITS   = (CNT_BITS > INDEX_W + 1) ? CNT_BITS : INDEX_W + 1;

   // command queue between front and back; a power of two so the pointers wrap by themselves
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int QPTR_BITS       = $clog2(CMD_QUEUE_DEPTH);
   localparam int QFILL_BITS      = $clog2(CMD_QUEUE_DEPTH + 1);

   localparam logic [TYPE_W-1:0] REQ_SET        = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_INS_BEFORE = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_INS_AFTER  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_REMOVE     = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_CLEAR      = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_READ       = 3'd6;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } ilir_status_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_SET,
      OP_INS_BEFORE,
      OP_INS_AFTER,
      OP_PUSH_BACK,
      OP_REMOVE,
      OP_CLEAR,
      OP_READ
   } ilir_op_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [INDEX_W-1:0] index;
      logic [DATA_W-1:0]  data;
   } ilir_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   read_data;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
   } ilir_rsp_type;

   // decoded command handed from front to back
   typedef struct packed {
      ilir_op_type          op;
      logic [INDEX_W-1:0]   index;
      logic [ELEM_BITS-1:0] elem;
   } ilir_cmd_type;

endpackage

// File: hdl/ilir_ram.sv
// ilir_ram: generic single-port ram, one address a cycle for a read, a write or both, registered read
// no dependencies
module ilir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata <= mem[addr];
      end
   end

endmodule

// File: hdl/ilir_front.sv
// ilir_front: takes request words, decodes them and queues them for the back end
// depends on ilir_pkg
module ilir_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  ilir_pkg::ilir_req_type req_item,
   output logic                  cmd_valid,
   input  logic                  cmd_pop,
   output ilir_pkg::ilir_cmd_type cmd
);

   localparam int DEPTH = ilir_pkg::CMD_QUEUE_DEPTH;
   localparam int PB    = ilir_pkg::QPTR_BITS;
   localparam int FB    = ilir_pkg::QFILL_BITS;

   ilir_pkg::ilir_cmd_type queue_ff [DEPTH];
   ilir_pkg::ilir_cmd_type dec;
   logic [PB-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [FB-1:0]          fill_ff, fill_in;
   logic                   do_push, do_pop;

   always_comb begin
      dec.index = req_item.index;
      dec.elem  = req_item.data[ilir_pkg::ELEM_BITS-1:0];
      case (req_item.req_type)
         ilir_pkg::REQ_SET:        dec.op = ilir_pkg::OP_SET;
         ilir_pkg::REQ_INS_BEFORE: dec.op = ilir_pkg::OP_INS_BEFORE;
         ilir_pkg::REQ_INS_AFTER:  dec.op = ilir_pkg::OP_INS_AFTER;
         ilir_pkg::REQ_PUSH_BACK:  dec.op = ilir_pkg::OP_PUSH_BACK;
         ilir_pkg::REQ_REMOVE:     dec.op = ilir_pkg::OP_REMOVE;
         ilir_pkg::REQ_CLEAR:      dec.op = ilir_pkg::OP_CLEAR;
         ilir_pkg::REQ_READ:       dec.op = ilir_pkg::OP_READ;
         default:                  dec.op = ilir_pkg::OP_NOP;
      endcase
   end

   assign full      = (fill_ff == FB'(DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      fill_in   = fill_ff + FB'(do_push) - FB'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= dec;
      end
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff <= FB'(DEPTH))
      else $error("queue fill past depth");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (fill_ff == $past(fill_ff) + FB'(1)))
      else $error("queue fill did not follow a push");
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers apart while empty");

endmodule

// File: hdl/ilir_back.sv
// ilir_back: carries out queued commands on the element ram and holds the reply word
// depends on ilir_pkg and ilir_ram
module ilir_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  ilir_pkg::ilir_cmd_type cmd,
   output logic                   empty,
   input  logic                   pop,
   output ilir_pkg::ilir_rsp_type rsp_item
);

   localparam int CB = ilir_pkg::CMP_BITS;
   localparam int AB = ilir_pkg::ADDR_BITS;
   localparam int EB = ilir_pkg::ELEM_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_ZERO, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR,
      S_WRITE, S_READ, S_RD_WAIT, S_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic [CB-1:0]                    ptr_ff, ptr_in;
   logic [CB-1:0]                    lim_ff, lim_in;
   logic [CB-1:0]                    tgt_ff, tgt_in;
   logic [CB-1:0]                    new_cnt_ff, new_cnt_in;
   logic [EB-1:0]                    elem_ff, elem_in;
   logic [EB-1:0]                    rd_ff, rd_in;
   ilir_pkg::ilir_status_type        status_ff, status_in;
   logic [ilir_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                             out_valid_ff, out_valid_in;
   ilir_pkg::ilir_rsp_type           out_ff, out_in;

   logic [CB-1:0] ix_w, cnt_w, cap_w, ptr_inc, ptr_dec;
   logic          out_pop, out_load;
   logic          ram_we, ram_re;
   logic [AB-1:0] ram_addr;
   logic [EB-1:0] ram_wdata, ram_rdata;

   ilir_ram #(.WIDTH(EB), .DEPTH(ilir_pkg::CAPACITY)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign ix_w    = CB'(cmd.index);
   assign cnt_w   = CB'(cnt_ff);
   assign cap_w   = CB'(ilir_pkg::CAPACITY);
   assign ptr_inc = ptr_ff + CB'(1);
   assign ptr_dec = ptr_ff - CB'(1);
   assign out_pop = pop && out_valid_ff;

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      lim_in     = lim_ff;
      tgt_in     = tgt_ff;
      new_cnt_in = new_cnt_ff;
      elem_in    = elem_ff;
      rd_in      = rd_ff;
      status_in  = status_ff;
      cnt_in     = cnt_ff;
      cmd_pop    = 1'b0;
      out_load   = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_addr   = ptr_ff[AB-1:0];
      ram_wdata  = '0;
      out_in     = out_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               elem_in    = cmd.elem;
               status_in  = ilir_pkg::ST_OK;
               rd_in      = '0;
               new_cnt_in = cnt_w;
               state_in   = S_DONE;
               case (cmd.op)
                  ilir_pkg::OP_SET: begin
                     tgt_in = ix_w;
                     if (ix_w >= cnt_w) begin
                        if (ix_w + CB'(1) > cap_w) begin
                           status_in = ilir_pkg::ST_FULL;
                        end else begin
                           ptr_in     = cnt_w;
                           lim_in     = ix_w;
                           new_cnt_in = ix_w + CB'(1);
                           state_in   = S_ZERO;
                        end
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
                  ilir_pkg::OP_INS_BEFORE, ilir_pkg::OP_INS_AFTER: begin
                     tgt_in = (cmd.op == ilir_pkg::OP_INS_AFTER) ? ix_w + CB'(1) : ix_w;
                     if (ix_w < cnt_w) begin
                        if (cnt_w + CB'(1) > cap_w) begin
                           status_in = ilir_pkg::ST_FULL;
                        end else begin
                           // whole tail moves up one slot, top first
                           ptr_in     = cnt_w;
                           lim_in     = (cmd.op == ilir_pkg::OP_INS_AFTER) ?
                                        ix_w + CB'(1) : ix_w;
                           new_cnt_in = cnt_w + CB'(1);
                           state_in   = S_UP_RD;
                        end
                     end else if (ix_w + CB'(2) > cap_w) begin
                        status_in = ilir_pkg::ST_FULL;
                     end else begin
                        ptr_in     = cnt_w;
                        lim_in     = ix_w + CB'(2);
                        new_cnt_in = ix_w + CB'(2);
                        state_in   = S_ZERO;
                     end
                  end
                  ilir_pkg::OP_PUSH_BACK: begin
                     if (cnt_w + CB'(1) > cap_w) begin
                        status_in = ilir_pkg::ST_FULL;
                     end else begin
                        tgt_in     = cnt_w;
                        new_cnt_in = cnt_w + CB'(1);
                        state_in   = S_WRITE;
                     end
                  end
                  ilir_pkg::OP_REMOVE: begin
                     if (ix_w >= cnt_w) begin
                        status_in = ilir_pkg::ST_RANGE;
                     end else begin
                        ptr_in     = ix_w;
                        lim_in     = cnt_w;
                        new_cnt_in = cnt_w - CB'(1);
                        state_in   = S_DN_RD;
                     end
                  end
                  ilir_pkg::OP_CLEAR: begin
                     new_cnt_in = '0;
                  end
                  ilir_pkg::OP_READ: begin
                     if (ix_w >= cnt_w) begin
                        status_in = ilir_pkg::ST_RANGE;
                     end else begin
                        ptr_in   = ix_w;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ZERO: begin
            // slots created by growth read back as zero
            if (ptr_ff < lim_ff) begin
               ram_we = 1'b1;
               ptr_in = ptr_inc;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_UP_RD: begin
            if (ptr_ff > lim_ff) begin
               ram_re   = 1'b1;
               ram_addr = ptr_dec[AB-1:0];
               state_in = S_UP_WR;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_UP_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            ptr_in    = ptr_dec;
            state_in  = S_UP_RD;
         end
         S_DN_RD: begin
            if (ptr_inc < lim_ff) begin
               ram_re   = 1'b1;
               ram_addr = ptr_inc[AB-1:0];
               state_in = S_DN_WR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DN_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            ptr_in    = ptr_inc;
            state_in  = S_DN_RD;
         end
         S_WRITE: begin
            ram_we    = 1'b1;
            ram_addr  = tgt_ff[AB-1:0];
            ram_wdata = elem_ff;
            state_in  = S_DONE;
         end
         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            rd_in    = ram_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || out_pop) begin
               out_load         = 1'b1;
               out_in.status    = status_ff;
               out_in.read_data = ilir_pkg::DATA_W'(rd_ff);
               out_in.count     = ilir_pkg::COUNT_W'(new_cnt_ff);
               out_in.is_empty  = (new_cnt_ff == '0);
               cnt_in           = new_cnt_ff[ilir_pkg::CNT_BITS-1:0];
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid_in = out_load || (out_valid_ff && !out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      ptr_ff     <= ptr_in;
      lim_ff     <= lim_in;
      tgt_ff     <= tgt_in;
      new_cnt_ff <= new_cnt_in;
      elem_ff    <= elem_in;
      rd_ff      <= rd_in;
      status_ff  <= status_in;
      out_ff     <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_item = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      CB'(cnt_ff) <= CB'(ilir_pkg::CAPACITY))
      else $error("element count past capacity");
   assert property (@(posedge clock) disable iff (reset) !(ram_we && ram_re))
      else $error("ram read and write in one cycle");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff != ilir_pkg::ST_OK) |-> (new_cnt_ff == CB'(cnt_ff)))
      else $error("failed request changes the count");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |=> $stable(out_ff))
      else $error("reply word changed while waiting");

endmodule

// File: hdl/indexed_list_insert_remove.sv
// A fixed-capacity ordered list of 8-bit elements, up to 1024 of them, driven by one request
// word per operation (set, insert before/after, push back, remove, clear, read) and answering
// each with one reply word carrying status, read data, the count after the request and an empty
// flag. Requests pass through a two-deep queue into a sequencer that owns a single-port element
// memory. Each request ends in a done state that loads the reply word; an element write first
// passes a write state, and a read a read and a wait state. Growth zeroes each new slot in turn,
// and an insert or remove moves each element with a read, then a write, so the longest request is
// an insert at the front of a list one short of capacity. One request is worked on at a time. The
// element memory needs no clearing after reset; only slots below the count are ever read.
// depends on ilir_pkg, ilir_front, ilir_back
module indexed_list_insert_remove (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  ilir_pkg::ilir_req_type req_item,
   output logic                   empty,
   input  logic                   pop,
   output ilir_pkg::ilir_rsp_type rsp_item
);

   logic                   cmd_valid;
   logic                   cmd_pop;
   ilir_pkg::ilir_cmd_type cmd;

   ilir_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   ilir_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for indexed_list_insert_remove, the indexed element list
// directed words from a table, then random words, each reply checked against typed-in values or a local list model
// depends on ilir_pkg and indexed_list_insert_remove
`timescale 1ns / 1ps

module tb_top;
   import ilir_pkg::*;

   localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;
   localparam int unsigned CYCLE_LIMIT      = 5_000_000;
   localparam int unsigned RANDOM_WORDS     = 420;
   localparam int          SCRIPT_LEN       = 28;

   typedef struct {
      logic [TYPE_W-1:0]   op;
      logic [INDEX_W-1:0]  index;
      logic [DATA_W-1:0]   data;
      bit                  fixed;
      ilir_status_type     status;
      logic [DATA_W-1:0]   rd;
      logic [COUNT_W-1:0]  cnt;
      logic                emp;
   } script_row_type;

   logic         clock;
   logic         reset    = 1'b1;
   logic         push     = 1'b0;
   logic         pop      = 1'b0;
   ilir_req_type req_item = '0;
   logic         full;
   logic         empty;
   ilir_rsp_type rsp_item;

   // local copy of the list
   logic [ELEM_BITS-1:0] list_mem [CAPACITY];
   int unsigned          list_len = 0;

   ilir_rsp_type pending_replies [$];
   int unsigned  mismatches  = 0;
   int unsigned  words_sent  = 0;
   int unsigned  send_idle   = 0;
   int unsigned  recv_idle   = 0;
   int unsigned  cycle_count = 0;

   // replies typed in where they follow at a glance; the rest come from the list model
   script_row_type script [SCRIPT_LEN] = '{
      '{REQ_READ,       10'd0,    8'h00, 1'b1, ST_RANGE, 8'h00, 11'd0,    1'b1},
      '{REQ_REMOVE,     10'd0,    8'h00, 1'b1, ST_RANGE, 8'h00, 11'd0,    1'b1},
      '{REQ_CLEAR,      10'd0,    8'h00, 1'b1, ST_OK,    8'h00, 11'd0,    1'b1},
      '{REQ_UNUSED,     10'd1023, 8'hFF, 1'b1, ST_OK,    8'h00, 11'd0,    1'b1},
      '{REQ_INS_BEFORE, 10'd1023, 8'h11, 1'b1, ST_FULL,  8'h00, 11'd0,    1'b1},
      '{REQ_INS_AFTER,  10'd1023, 8'h22, 1'b1, ST_FULL,  8'h00, 11'd0,    1'b1},
      '{REQ_SET,        10'd1023, 8'hFF, 1'b1, ST_OK,    8'h00, 11'd1024, 1'b0},
      '{REQ_PUSH_BACK,  10'd0,    8'h5A, 1'b1, ST_FULL,  8'h00, 11'd1024, 1'b0},
      '{REQ_INS_BEFORE, 10'd0,    8'h11, 1'b1, ST_FULL,  8'h00, 11'd1024, 1'b0},
      '{REQ_INS_AFTER,  10'd512,  8'h22, 1'b1, ST_FULL,  8'h00, 11'd1024, 1'b0},
      '{REQ_READ,       10'd1023, 8'h00, 1'b1, ST_OK,    8'hFF, 11'd1024, 1'b0},
      '{REQ_READ,       10'd0,    8'h00, 1'b1, ST_OK,    8'h00, 11'd1024, 1'b0},
      '{REQ_REMOVE,     10'd0,    8'h00, 1'b1, ST_OK,    8'h00, 11'd1023, 1'b0},
      '{REQ_READ,       10'd1022, 8'h00, 1'b1, ST_OK,    8'hFF, 11'd1023, 1'b0},
      '{REQ_CLEAR,      10'd0,    8'h00, 1'b1, ST_OK,    8'h00, 11'd0,    1'b1},
      '{REQ_INS_AFTER,  10'd1022, 8'h80, 1'b1, ST_OK,    8'h00, 11'd1024, 1'b0},
      '{REQ_READ,       10'd1023, 8'h00, 1'b1, ST_OK,    8'h80, 11'd1024, 1'b0},
      '{REQ_REMOVE,     10'd1023, 8'h00, 1'b1, ST_OK,    8'h00, 11'd1023, 1'b0},
      '{REQ_CLEAR,      10'd0,    8'h00, 1'b1, ST_OK,    8'h00, 11'd0,    1'b1},
      '{REQ_PUSH_BACK,  10'd0,    8'hAA, 1'b1, ST_OK,    8'h00, 11'd1,    1'b0},
      '{REQ_INS_BEFORE, 10'd0,    8'h55, 1'b0, ST_OK,    8'h00, 11'd0,    1'b0},
      '{REQ_INS_AFTER,  10'd0,    8'h33, 1'b0, ST_OK,    8'h00, 11'd0,    1'b0},
      '{REQ_READ,       10'd1,    8'h00, 1'b0, ST_OK,    8'h00, 11'd0,    1'b0},
      '{REQ_SET,        10'd5,    8'h0F, 1'b0, ST_OK,    8'h00, 11'd0,    1'b0},
      '{REQ_INS_BEFORE, 10'd9,    8'h01, 1'b0, ST_OK,    8'h00, 11'd0,    1'b0},
      '{REQ_REMOVE,     10'd2,    8'h00, 1'b0, ST_OK,    8'h00, 11'd0,    1'b0},
      '{REQ_READ,       10'd3,    8'h00, 1'b0, ST_OK,    8'h00, 11'd0,    1'b0},
      '{REQ_SET,        10'd1,    8'hF0, 1'b0, ST_OK,    8'h00, 11'd0,    1'b0}
   };

   indexed_list_insert_remove i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // zero the slots that growth creates
   function automatic void grow_list(int unsigned from, int unsigned upto);
      for (int unsigned i = from; i < upto; i++) list_mem[i] = '0;
      list_len = upto;
   endfunction

   function automatic ilir_rsp_type apply_request(ilir_req_type r);
      ilir_rsp_type rsp;
      int unsigned  ix;
      int unsigned  n;
      int unsigned  pos;
      ix  = r.index;
      n   = list_len;
      rsp = '0;
      rsp.status = ST_OK;
      case (r.req_type)
         REQ_SET: begin
            if (ix >= n && ix + 1 > CAPACITY) rsp.status = ST_FULL;
            else begin
               if (ix >= n) grow_list(n, ix + 1);
               list_mem[ix] = r.data;
            end
         end
         REQ_INS_BEFORE, REQ_INS_AFTER: begin
            pos = (r.req_type == REQ_INS_BEFORE) ? ix : ix + 1;
            if (ix < n) begin
               if (n + 1 > CAPACITY) rsp.status = ST_FULL;
               else begin
                  for (int unsigned i = n; i > pos; i--) list_mem[i] = list_mem[i - 1];
                  list_mem[pos] = r.data;
                  list_len      = n + 1;
               end
            end else if (ix + 2 > CAPACITY) rsp.status = ST_FULL;
            else begin
               grow_list(n, ix + 2);
               list_mem[pos] = r.data;
            end
         end
         REQ_PUSH_BACK: begin
            if (n + 1 > CAPACITY) rsp.status = ST_FULL;
            else begin
               list_mem[n] = r.data;
               list_len    = n + 1;
            end
         end
         REQ_REMOVE: begin
            if (ix >= n) rsp.status = ST_RANGE;
            else begin
               for (int unsigned i = ix; i + 1 < n; i++) list_mem[i] = list_mem[i + 1];
               list_len = n - 1;
            end
         end
         REQ_CLEAR: list_len = 0;
         REQ_READ: begin
            if (ix >= n) rsp.status = ST_RANGE;
            else rsp.read_data = list_mem[ix];
         end
         default: ;
      endcase
      rsp.count    = COUNT_W'(list_len);
      rsp.is_empty = (list_len == 0);
      return rsp;
   endfunction

   // mostly well-formed edits on a short list, with rare far-off growth and stray indexes
   function automatic ilir_req_type pick_random_word();
      ilir_req_type w;
      int unsigned  roll;
      int unsigned  sel;
      int unsigned  n;
      n      = list_len;
      roll   = $urandom_range(99);
      sel    = $urandom_range(9);
      w.data = DATA_W'($urandom);
      w.index = INDEX_W'($urandom);
      if (n > 48 && $urandom_range(1) == 1) w.req_type = REQ_CLEAR;
      else if (roll < 2) w.req_type = REQ_UNUSED;
      else if (roll < 4) w.req_type = TYPE_W'($urandom_range(REQ_INS_AFTER, REQ_SET));
      else if (roll < 7) w.req_type = REQ_CLEAR;
      else if (roll < 20) w.req_type = REQ_PUSH_BACK;
      else if (roll < 35) begin
         w.req_type = REQ_SET;
         w.index    = INDEX_W'($urandom_range(n + 2));
      end else if (roll < 55) begin
         w.req_type = TYPE_W'($urandom_range(REQ_INS_AFTER, REQ_INS_BEFORE));
         w.index    = INDEX_W'($urandom_range(n + 1));
      end else begin
         w.req_type = (roll < 70) ? REQ_REMOVE : REQ_READ;
         if (n > 0 && sel < 7) w.index = INDEX_W'($urandom_range(n - 1));
         else if (sel < 9) w.index = INDEX_W'(n);
      end
      return w;
   endfunction

   task automatic send_word(ilir_req_type w);
      if (words_sent < 160) begin
         send_idle = 31;
         recv_idle = 60;
      end else if (words_sent < 320) begin
         send_idle = 60;
         recv_idle = 31;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= w;
      do @(posedge clock); while (full);
      words_sent++;
   endtask

   task automatic check_reply(ilir_rsp_type got);
      ilir_rsp_type want;
      if (pending_replies.size() == 0) begin
         $error("reply word with no request pending: %p", got);
         mismatches++;
         return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         mismatches++;
      end
      if (got.read_data !== want.read_data) begin
         $error("read_data: expected 0x%02h, got 0x%02h", want.read_data, got.read_data);
         mismatches++;
      end
      if (got.count !== want.count) begin
         $error("count: expected %0d, got %0d", want.count, got.count);
         mismatches++;
      end
      if (got.is_empty !== want.is_empty) begin
         $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
         mismatches++;
      end
   endtask

   task automatic collect_replies();
      forever begin
         pop <= ($urandom_range(99) >= recv_idle);
         @(posedge clock);
         if (pop && !empty) check_reply(rsp_item);
      end
   endtask

   initial begin
      ilir_req_type w;
      ilir_rsp_type predicted;
      int unsigned  useful;
      useful = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      fork
         collect_replies();
      join_none

      foreach (script[k]) begin
         w.req_type = script[k].op;
         w.index    = script[k].index;
         w.data     = script[k].data;
         send_word(w);
         predicted = apply_request(w);
         if (script[k].fixed)
            pending_replies.push_back('{script[k].status, script[k].rd, script[k].cnt,
                                        script[k].emp});
         else
            pending_replies.push_back(predicted);
      end

      while (useful < RANDOM_WORDS) begin
         w = pick_random_word();
         send_word(w);
         pending_replies.push_back(apply_request(w));
         // unused codes change nothing in the block but still get a reply
         if (w.req_type != REQ_UNUSED) useful++;
      end
      push <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// File: filelist.f
hdl/ilir_pkg.sv
hdl/ilir_ram.sv
hdl/ilir_front.sv
hdl/ilir_back.sv
hdl/indexed_list_insert_remove.sv
tb/tb_top.sv
